/* src/mffm_pkg.sv */
// Package with shared command codes, headings and payload types of the maze map.
`timescale 1ns / 1ps
`default_nettype none

package mffm_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_ADD   = 3'd1,
        CMD_FLOOD = 3'd2,
        CMD_BEST  = 3'd3,
        CMD_QUERY = 3'd4
    } cmd_t;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam int          CELL_AW   = 8;
    localparam logic [7:0]  UNREACHED = 8'd255;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] x_coord;
        logic [3:0] y_coord;
        logic [1:0] heading;
    } in_t;

    typedef struct packed {
        logic [1:0] best_heading;
        logic       wall_present;
    } out_t;

endpackage

`default_nettype wire

/* src/mffm_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mffm_ram #(
    parameter int WIDTH = 8
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [mffm_pkg::CELL_AW-1:0] wa,
    input  wire logic [WIDTH-1:0]             wd,
    input  wire logic [mffm_pkg::CELL_AW-1:0] ra,
    output logic      [WIDTH-1:0]             rd
);

    logic [WIDTH-1:0] mem [2**mffm_pkg::CELL_AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule

`default_nettype wire

/* src/maze_flood_fill_map.sv */
// Top level of the maze map: command sequencer over wall, distance and queue memories.
`timescale 1ns / 1ps
`default_nettype none

// Maze map for a ROWS x COLS grid. A command is taken when start is high and
// busy is low; its single result shows on result for one cycle with done high,
// and the receiver cannot stall it. Walls, distances and the flood queue live
// in three 256-entry synchronous RAMs with registered read data; walls and
// distances are addressed by {row, column}, so each command is a sequence
// of RAM reads and writes. Best move makes one RAM read per open
// neighbour. Add, best move and query on an off-grid cell go straight to the
// result. Clear map rewrites every entry of the wall and distance RAMs. Flood
// first sweeps the distance RAM once to restore 255; with the target on the
// grid it then seeds the target and reads the neighbours of each queued cell
// one at a time, and with the target off the grid it stops after the sweep.
// After reset the block runs a clearing pass over all 256 entries of the wall
// and distance RAMs with busy high and no result.
module maze_flood_fill_map #(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire mffm_pkg::in_t  command,
    output logic                done,
    output mffm_pkg::out_t      result
);

    localparam logic [4:0] ROWS_W = 5'(ROWS);
    localparam logic [4:0] COLS_W = 5'(COLS);
    localparam logic [3:0] LAST_ROW = 4'(ROWS - 1);
    localparam logic [3:0] LAST_COL = 4'(COLS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SWEEP, S_SEED, S_QRD, S_CRD, S_CGOT, S_NISSUE, S_NEVAL,
        S_BWALL, S_QWALL, S_AW1, S_AW2, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        M_WALL, M_FLOOD, M_BEST
    } mode_t;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [3:0]          cx_reg, cx_next;
    logic [3:0]          cy_reg, cy_next;
    logic [1:0]          h_reg, h_next;
    logic [1:0]          k_reg, k_next;
    logic [3:0]          cw_reg, cw_next;
    logic [7:0]          cd_reg, cd_next;
    logic [7:0]          best_reg, best_next;
    logic [1:0]          pick_reg, pick_next;
    logic                wp_reg, wp_next;
    logic [7:0]          sweep_reg, sweep_next;
    logic                sweep_clr_reg, sweep_clr_next;
    logic                boot_reg, boot_next;
    logic [8:0]          head_reg, head_next;
    logic [8:0]          tail_reg, tail_next;
    logic [7:0]          naddr_reg, naddr_next;
    logic                done_reg, done_next;
    mffm_pkg::out_t      res_reg, res_next;

    logic                wall_we, dist_we, queue_we;
    logic [7:0]          wall_wa, dist_wa, queue_wa;
    logic [3:0]          wall_wd;
    logic [7:0]          dist_wd, queue_wd;
    logic [7:0]          wall_ra, dist_ra, queue_ra;
    logic [3:0]          wall_rd;
    logic [7:0]          dist_rd, queue_rd;

    logic [1:0]          hsel;
    logic                nvalid;
    logic [3:0]          nx, ny;
    logic                in_grid_cmd;
    logic                in_grid_cur;
    logic [3:0]          sweep_walls;
    logic [8:0]          cd_inc;

    mffm_ram #(.WIDTH(4)) u_wall (
        .clk (clk), .we (wall_we), .wa (wall_wa), .wd (wall_wd),
        .ra  (wall_ra), .rd (wall_rd)
    );

    mffm_ram #(.WIDTH(8)) u_dist (
        .clk (clk), .we (dist_we), .wa (dist_wa), .wd (dist_wd),
        .ra  (dist_ra), .rd (dist_rd)
    );

    mffm_ram #(.WIDTH(8)) u_queue (
        .clk (clk), .we (queue_we), .wa (queue_wa), .wd (queue_wd),
        .ra  (queue_ra), .rd (queue_rd)
    );

    // Heading under test: flood walks N, E, S, W; best move tries straight,
    // right, left, back; add wall uses the commanded side.
    always_comb
    begin
        case (mode_reg)
            M_FLOOD: hsel = k_reg;
            M_BEST:
            begin
                case (k_reg)
                    2'd0:    hsel = h_reg;
                    2'd1:    hsel = h_reg + 2'd1;
                    2'd2:    hsel = h_reg + 2'd3;
                    default: hsel = h_reg + 2'd2;
                endcase
            end
            default: hsel = h_reg;
        endcase
    end

    // Neighbour of the current cell; off-grid neighbours are not valid.
    always_comb
    begin
        nx = cx_reg;
        ny = cy_reg;
        case (hsel)
            mffm_pkg::DIR_N:
            begin
                nvalid = (cy_reg != 4'd0);
                ny     = cy_reg - 4'd1;
            end
            mffm_pkg::DIR_E:
            begin
                nvalid = (({1'b0, cx_reg} + 5'd1) < COLS_W);
                nx     = cx_reg + 4'd1;
            end
            mffm_pkg::DIR_S:
            begin
                nvalid = (({1'b0, cy_reg} + 5'd1) < ROWS_W);
                ny     = cy_reg + 4'd1;
            end
            default:
            begin
                nvalid = (cx_reg != 4'd0);
                nx     = cx_reg - 4'd1;
            end
        endcase
    end

    assign in_grid_cmd = ({1'b0, command.x_coord} < COLS_W) &&
                         ({1'b0, command.y_coord} < ROWS_W);
    assign in_grid_cur = ({1'b0, cx_reg} < COLS_W) && ({1'b0, cy_reg} < ROWS_W);

    // Boundary walls of the entry under the sweep: bit h is side h.
    assign sweep_walls = {(sweep_reg[3:0] == 4'd0),
                          (sweep_reg[7:4] == LAST_ROW),
                          (sweep_reg[3:0] == LAST_COL),
                          (sweep_reg[7:4] == 4'd0)};

    assign cd_inc = {1'b0, cd_reg} + 9'd1;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        cmd_next       = cmd_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        cw_next        = cw_reg;
        cd_next        = cd_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        wp_next        = wp_reg;
        sweep_next     = sweep_reg;
        sweep_clr_next = sweep_clr_reg;
        boot_next      = boot_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        naddr_next     = naddr_reg;
        done_next      = 1'b0;
        res_next       = res_reg;

        wall_we  = 1'b0;
        wall_wa  = {cy_reg, cx_reg};
        wall_wd  = wall_rd;
        dist_we  = 1'b0;
        dist_wa  = naddr_reg;
        dist_wd  = cd_inc[7:0];
        queue_we = 1'b0;
        queue_wa = tail_reg[7:0];
        queue_wd = naddr_reg;
        wall_ra  = {cy_reg, cx_reg};
        dist_ra  = {ny, nx};
        queue_ra = head_reg[7:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command.cmd;
                    cx_next    = command.x_coord;
                    cy_next    = command.y_coord;
                    h_next     = command.heading;
                    pick_next  = command.heading;
                    wp_next    = 1'b0;
                    sweep_next = '0;
                    wall_ra    = {command.y_coord, command.x_coord};
                    case (command.cmd)
                        mffm_pkg::CMD_CLEAR:
                        begin
                            sweep_clr_next = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        mffm_pkg::CMD_ADD:
                        begin
                            mode_next  = M_WALL;
                            state_next = in_grid_cmd ? S_AW1 : S_FIN;
                        end
                        mffm_pkg::CMD_FLOOD:
                        begin
                            mode_next      = M_FLOOD;
                            sweep_clr_next = 1'b0;
                            head_next      = '0;
                            tail_next      = '0;
                            state_next     = S_SWEEP;
                        end
                        mffm_pkg::CMD_BEST:
                        begin
                            mode_next  = M_BEST;
                            state_next = in_grid_cmd ? S_BWALL : S_FIN;
                        end
                        mffm_pkg::CMD_QUERY:
                        begin
                            mode_next  = M_WALL;
                            wp_next    = !in_grid_cmd;
                            state_next = in_grid_cmd ? S_QWALL : S_FIN;
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end

            S_SWEEP:
            begin
                dist_we    = 1'b1;
                dist_wa    = sweep_reg;
                dist_wd    = mffm_pkg::UNREACHED;
                wall_we    = sweep_clr_reg;
                wall_wa    = sweep_reg;
                wall_wd    = sweep_walls;
                sweep_next = sweep_reg + 8'd1;
                if (sweep_reg == 8'hFF)
                begin
                    if (boot_reg)
                    begin
                        boot_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else if (!sweep_clr_reg && in_grid_cur)
                    begin
                        state_next = S_SEED;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end

            S_SEED:
            begin
                dist_we    = 1'b1;
                dist_wa    = {cy_reg, cx_reg};
                dist_wd    = 8'd0;
                queue_we   = 1'b1;
                queue_wa   = 8'd0;
                queue_wd   = {cy_reg, cx_reg};
                tail_next  = 9'd1;
                state_next = S_QRD;
            end

            S_QRD:
            begin
                if ((head_reg == tail_reg) || head_reg[8])
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    head_next  = head_reg + 9'd1;
                    state_next = S_CRD;
                end
            end

            S_CRD:
            begin
                cx_next    = queue_rd[3:0];
                cy_next    = queue_rd[7:4];
                wall_ra    = queue_rd;
                dist_ra    = queue_rd;
                state_next = S_CGOT;
            end

            S_CGOT:
            begin
                cw_next    = wall_rd;
                cd_next    = dist_rd;
                k_next     = 2'd0;
                state_next = S_NISSUE;
            end

            S_BWALL:
            begin
                cw_next    = wall_rd;
                k_next     = 2'd0;
                best_next  = mffm_pkg::UNREACHED;
                state_next = S_NISSUE;
            end

            S_NISSUE:
            begin
                naddr_next = {ny, nx};
                if (!cw_reg[hsel] && nvalid)
                begin
                    state_next = S_NEVAL;
                end
                else if (k_reg == 2'd3)
                begin
                    state_next = (mode_reg == M_FLOOD) ? S_QRD : S_FIN;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end

            S_NEVAL:
            begin
                if (mode_reg == M_FLOOD)
                begin
                    if ({1'b0, dist_rd} > cd_inc)
                    begin
                        dist_we = 1'b1;
                        if (!tail_reg[8])
                        begin
                            queue_we  = 1'b1;
                            tail_next = tail_reg + 9'd1;
                        end
                    end
                end
                else if (dist_rd < best_reg)
                begin
                    best_next = dist_rd;
                    pick_next = hsel;
                end
                if (k_reg == 2'd3)
                begin
                    state_next = (mode_reg == M_FLOOD) ? S_QRD : S_FIN;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_NISSUE;
                end
            end

            S_QWALL:
            begin
                wp_next    = wall_rd[h_reg];
                state_next = S_FIN;
            end

            S_AW1:
            begin
                // Mark this side, then fetch the neighbour for its mirror.
                wall_we    = 1'b1;
                wall_wd    = wall_rd | (4'b0001 << h_reg);
                wall_ra    = {ny, nx};
                naddr_next = {ny, nx};
                state_next = nvalid ? S_AW2 : S_FIN;
            end

            S_AW2:
            begin
                wall_we    = 1'b1;
                wall_wa    = naddr_reg;
                wall_wd    = wall_rd | (4'b0001 << (h_reg + 2'd2));
                state_next = S_FIN;
            end

            S_FIN:
            begin
                done_next             = 1'b1;
                res_next.best_heading = (cmd_reg == mffm_pkg::CMD_BEST) ? pick_reg : 2'd0;
                res_next.wall_present = (cmd_reg == mffm_pkg::CMD_QUERY) ? wp_reg : 1'b0;
                state_next            = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            mode_reg      <= M_WALL;
            sweep_reg     <= '0;
            sweep_clr_reg <= 1'b1;
            boot_reg      <= 1'b1;
            head_reg      <= '0;
            tail_reg      <= '0;
            done_reg      <= 1'b0;
            res_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            sweep_reg     <= sweep_next;
            sweep_clr_reg <= sweep_clr_next;
            boot_reg      <= boot_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            done_reg      <= done_next;
            res_reg       <= res_next;
            k_reg         <= k_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        h_reg     <= h_next;
        cw_reg    <= cw_next;
        cd_reg    <= cd_next;
        best_reg  <= best_next;
        pick_reg  <= pick_next;
        wp_reg    <= wp_next;
        naddr_reg <= naddr_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

/* src/mffm_checker.sv */
// Port-level checker for the maze map, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mffm_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire mffm_pkg::out_t result
);

    // An accepted command always occupies the block.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // A result comes out only as the block goes idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result without finishing a command");

    // Never two results in a row: each needs an accepted command.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Only one output field can be nonzero for any command.
    a_fields_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.wall_present |-> result.best_heading == 2'd0)
        else $error("both result fields set");

endmodule

bind maze_flood_fill_map mffm_checker u_mffm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
